// ===== src/uyvy_pkg.sv =====
// ----------------------------------------------------------------------------
// UYVY converter package
// Shared payload types, color matrix coefficients and output helpers.
// ----------------------------------------------------------------------------
package uyvy_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned RGB565_W = 16;
  // Width of the chroma terms once the products are scaled down by 256.
  localparam int unsigned TERM_W   = 10;
  // Width of a channel before clamping: luma plus a chroma term.
  localparam int unsigned SUM_W    = 11;
  // Product of a signed 9-bit chroma by a 9-bit positive coefficient.
  localparam int unsigned PROD_W   = 18;

  localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
  localparam logic [PIX_W-1:0] COEF_RV       = 8'd103;
  localparam logic [PIX_W-1:0] COEF_GU       = 8'd88;
  localparam logic [PIX_W-1:0] COEF_GV       = 8'd183;
  localparam logic [PIX_W-1:0] COEF_BU       = 8'd198;
  localparam logic [PIX_W-1:0] CHAN_MAX      = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] chroma_u;
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_v;
    logic [PIX_W-1:0] luma_second;
    logic             frame_end_in;
  } uyvy_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]    red_first;
    logic [PIX_W-1:0]    green_first;
    logic [PIX_W-1:0]    blue_first;
    logic [RGB565_W-1:0] packed_first;
    logic [PIX_W-1:0]    red_second;
    logic [PIX_W-1:0]    green_second;
    logic [PIX_W-1:0]    blue_second;
    logic [RGB565_W-1:0] packed_second;
    logic                frame_end_out;
  } uyvy_out_t;

  // Fields that ride along the chroma pipeline unchanged.
  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] luma_second;
    logic             frame_end;
  } uyvy_side_t;

  // Chroma contributions shared by both pixels of a macropixel.
  typedef struct packed {
    logic signed [TERM_W-1:0] red_term;
    logic signed [TERM_W-1:0] green_term;
    logic signed [TERM_W-1:0] blue_term;
  } uyvy_chroma_t;

  function automatic logic [PIX_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] x);
    logic [PIX_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > $signed({3'b000, CHAN_MAX})) begin
      res = CHAN_MAX;
    end else begin
      res = x[PIX_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [RGB565_W-1:0] pack_565(input logic [PIX_W-1:0] r,
                                                  input logic [PIX_W-1:0] g,
                                                  input logic [PIX_W-1:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

// ===== src/uyvy_chroma.sv =====
// ----------------------------------------------------------------------------
// UYVY chroma pipeline
// Two register stages: chroma products, then the scaled chroma terms.
// ----------------------------------------------------------------------------
module uyvy_chroma
  import uyvy_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [PIX_W-1:0] in_u,
  input  logic [PIX_W-1:0] in_v,
  input  uyvy_side_t       in_side,
  output logic             out_valid,
  output uyvy_chroma_t     out_chroma,
  output uyvy_side_t       out_side
);

  // Product stage.
  logic                      prod_valid_r;
  logic signed [PIX_W:0]     u_r, v_r;
  logic signed [PROD_W-1:0]  p_rv_r, p_gu_r, p_gv_r, p_bu_r;
  logic signed [PIX_W:0]     u_nxt, v_nxt;
  logic signed [PROD_W-1:0]  p_rv_nxt, p_gu_nxt, p_gv_nxt, p_bu_nxt;
  uyvy_side_t                prod_side_r;

  // Term stage.
  logic                      term_valid_r;
  uyvy_chroma_t              term_r, term_nxt;
  uyvy_side_t                term_side_r;

  always_comb begin
    u_nxt    = $signed({1'b0, in_u}) - $signed({1'b0, CHROMA_OFFSET});
    v_nxt    = $signed({1'b0, in_v}) - $signed({1'b0, CHROMA_OFFSET});
    p_rv_nxt = v_nxt * $signed({1'b0, COEF_RV});
    p_gu_nxt = u_nxt * $signed({1'b0, COEF_GU});
    p_gv_nxt = v_nxt * $signed({1'b0, COEF_GV});
    p_bu_nxt = u_nxt * $signed({1'b0, COEF_BU});
  end

  // Taking the upper bits of a product is a floor division by 256.
  always_comb begin
    term_nxt.red_term   = {v_r[PIX_W], v_r} + p_rv_r[PROD_W-1:8];
    term_nxt.green_term = p_gu_r[PROD_W-1:8] + p_gv_r[PROD_W-1:8];
    term_nxt.blue_term  = {u_r[PIX_W], u_r} + p_bu_r[PROD_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      term_valid_r <= 1'b0;
    end else begin
      prod_valid_r <= in_valid;
      term_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    u_r         <= u_nxt;
    v_r         <= v_nxt;
    p_rv_r      <= p_rv_nxt;
    p_gu_r      <= p_gu_nxt;
    p_gv_r      <= p_gv_nxt;
    p_bu_r      <= p_bu_nxt;
    prod_side_r <= in_side;
    term_r      <= term_nxt;
    term_side_r <= prod_side_r;
  end

  assign out_valid  = term_valid_r;
  assign out_chroma = term_r;
  assign out_side   = term_side_r;

endmodule

// ===== src/uyvy_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// UYVY to RGB converter
// Converts one UYVY macropixel per clock into two RGB888 / RGB565 pixels.
// ----------------------------------------------------------------------------
// Usage: drive one macropixel on in_data and raise start for one cycle; the
// transfer takes place at that rising edge. busy is always low, so a new
// macropixel may be given in every cycle.
// Each transfer yields exactly one result: out_valid is high for one cycle
// with both converted pixels and the copied last-of-frame flag on out_data.
// From the accepting edge, a result passes through the register stages below;
// throughput is one macropixel per cycle.
// The four register stages are: input capture, chroma products, scaled
// chroma terms, and luma add with clamp and RGB565 packing.
// The receiver cannot stall, so nothing is ever held back; results appear
// in the order of the transfers.
// Reset clears all valid bits at once; no result appears for an item still
// in flight when reset is applied.
// ----------------------------------------------------------------------------
module uyvy_to_rgb_converter
  import uyvy_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  uyvy_in_t  in_data,
  output logic      out_valid,
  output uyvy_out_t out_data
);

  logic         cap_valid_r;
  uyvy_in_t     cap_r;
  uyvy_side_t   cap_side;

  logic         chr_valid;
  uyvy_chroma_t chr;
  uyvy_side_t   chr_side;

  logic         out_valid_r;
  uyvy_out_t    out_r, out_nxt;

  logic signed [SUM_W-1:0] r0, g0, b0, r1, g1, b1;
  logic signed [SUM_W-1:0] y0, y1, rt, gt, bt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cap_valid_r <= start && !busy;
      out_valid_r <= chr_valid;
    end
  end

  always_ff @(posedge clk) begin
    cap_r <= in_data;
    out_r <= out_nxt;
  end

  always_comb begin
    cap_side.luma_first  = cap_r.luma_first;
    cap_side.luma_second = cap_r.luma_second;
    cap_side.frame_end   = cap_r.frame_end_in;
  end

  uyvy_chroma u_chroma (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (cap_valid_r),
    .in_u       (cap_r.chroma_u),
    .in_v       (cap_r.chroma_v),
    .in_side    (cap_side),
    .out_valid  (chr_valid),
    .out_chroma (chr),
    .out_side   (chr_side)
  );

  always_comb begin
    y0 = $signed({3'b000, chr_side.luma_first});
    y1 = $signed({3'b000, chr_side.luma_second});
    rt = {chr.red_term[TERM_W-1], chr.red_term};
    gt = {chr.green_term[TERM_W-1], chr.green_term};
    bt = {chr.blue_term[TERM_W-1], chr.blue_term};
    r0 = y0 + rt;
    g0 = y0 - gt;
    b0 = y0 + bt;
    r1 = y1 + rt;
    g1 = y1 - gt;
    b1 = y1 + bt;

    out_nxt.red_first     = clamp_chan(r0);
    out_nxt.green_first   = clamp_chan(g0);
    out_nxt.blue_first    = clamp_chan(b0);
    out_nxt.packed_first  = pack_565(out_nxt.red_first, out_nxt.green_first,
                                     out_nxt.blue_first);
    out_nxt.red_second    = clamp_chan(r1);
    out_nxt.green_second  = clamp_chan(g1);
    out_nxt.blue_second   = clamp_chan(b1);
    out_nxt.packed_second = pack_565(out_nxt.red_second, out_nxt.green_second,
                                     out_nxt.blue_second);
    out_nxt.frame_end_out = chr_side.frame_end;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Every transfer produces a result once it has passed through the pipeline.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("transfer did not produce a result after four cycles");

  // No result appears without a matching transfer made while out of reset.
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start, 4) && $past(rst_n, 4)))
    else $error("result without a matching transfer");

  // The packed word of the first pixel agrees with its 8-bit channels.
  a_pack_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.packed_first[15:11] == out_data.red_first[7:3] &&
                   out_data.packed_first[10:5] == out_data.green_first[7:2] &&
                   out_data.packed_first[4:0] == out_data.blue_first[7:3]))
    else $error("RGB565 word of first pixel disagrees with its channels");

  // The frame flag reaches the output together with the result of its transfer.
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 (out_data.frame_end_out == $past(in_data.frame_end_in, 4)))
    else $error("last-of-frame flag not carried through");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// UYVY to RGB converter testbench
// Sends UYVY macropixels to the converter, with directed corner cases first
// and random ones after. A built-in predictor computes both RGB888 / RGB565
// pixels of each transfer, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uyvy_pkg::*;

  localparam int CHROMA_BIAS   = 128;
  localparam int RANDOM_ITEMS  = 550;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_PRINTED   = 40;
  // The driver does not idle while this range of items is sent.
  localparam int QUIET_FIRST   = 200;
  localparam int QUIET_LAST    = 330;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  uyvy_in_t  in_data = '0;
  logic      out_valid;
  uyvy_out_t out_data;

  uyvy_in_t  macropixel_queue[$];
  uyvy_out_t rgb_expected[$];
  logic      took_item = 1'b0;
  int        sent_count = 0;
  int        error_count = 0;

  uyvy_to_rgb_converter dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [7:0] saturate(input int x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // Products are scaled by an arithmetic shift, which floors negative values.
  function automatic void convert_pixel(input int y, input int u, input int v,
                                        output logic [7:0] r, output logic [7:0] g,
                                        output logic [7:0] b,
                                        output logic [15:0] rgb565);
    r = saturate(y + v + ((v * 103) >>> 8));
    g = saturate(y - ((u * 88) >>> 8) - ((v * 183) >>> 8));
    b = saturate(y + u + ((u * 198) >>> 8));
    rgb565 = {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic uyvy_out_t convert_macropixel(input uyvy_in_t m);
    uyvy_out_t res;
    int u;
    int v;
    u = int'(m.chroma_u) - CHROMA_BIAS;
    v = int'(m.chroma_v) - CHROMA_BIAS;
    convert_pixel(int'(m.luma_first), u, v, res.red_first, res.green_first,
                  res.blue_first, res.packed_first);
    convert_pixel(int'(m.luma_second), u, v, res.red_second, res.green_second,
                  res.blue_second, res.packed_second);
    res.frame_end_out = m.frame_end_in;
    return res;
  endfunction

  function automatic uyvy_in_t make_item(input int u, input int y0, input int v,
                                         input int y1, input bit fe);
    uyvy_in_t m;
    m.chroma_u     = u[7:0];
    m.luma_first   = y0[7:0];
    m.chroma_v     = v[7:0];
    m.luma_second  = y1[7:0];
    m.frame_end_in = fe;
    return m;
  endfunction

  // Chroma near its extremes and its zero point is where clamping and the
  // floor of negative products matter most, so it is picked often.
  function automatic logic [7:0] pick_chroma();
    logic [7:0] edges[7];
    logic [7:0] res;
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(99) < 25) begin
      res = edges[$urandom_range(6)];
    end else begin
      res = 8'($urandom);
    end
    return res;
  endfunction

  function automatic uyvy_in_t random_macropixel();
    uyvy_in_t m;
    m.chroma_u     = pick_chroma();
    m.luma_first   = 8'($urandom);
    m.chroma_v     = pick_chroma();
    m.luma_second  = 8'($urandom);
    m.frame_end_in = ($urandom_range(7) == 0);
    return m;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    error_count++;
  endtask

  task automatic check_field(input string field, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
    end
  endtask

  // Driver: a new transfer is offered at the falling edge once the previous
  // one has been taken.
  always @(negedge clk) begin
    if (rst_n && (!start || took_item)) begin
      if (macropixel_queue.size() > 0 &&
          ((sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) ||
           $urandom_range(99) >= 17)) begin
        in_data <= macropixel_queue.pop_front();
        start <= 1'b1;
        sent_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: records accepted transfers and checks each result strobe.
  always @(posedge clk) begin
    uyvy_out_t want;
    if (!rst_n) begin
      took_item <= 1'b0;
    end else begin
      took_item <= start && !busy;
      if (out_valid) begin
        if (rgb_expected.size() == 0) begin
          report_mismatch("result with no transfer waiting for it");
        end else begin
          want = rgb_expected.pop_front();
          check_field("red_first", out_data.red_first, want.red_first);
          check_field("green_first", out_data.green_first, want.green_first);
          check_field("blue_first", out_data.blue_first, want.blue_first);
          check_field("packed_first", out_data.packed_first, want.packed_first);
          check_field("red_second", out_data.red_second, want.red_second);
          check_field("green_second", out_data.green_second, want.green_second);
          check_field("blue_second", out_data.blue_second, want.blue_second);
          check_field("packed_second", out_data.packed_second, want.packed_second);
          check_field("frame_end_out", out_data.frame_end_out, want.frame_end_out);
        end
      end
      if (start && !busy) begin
        rgb_expected.push_back(convert_macropixel(in_data));
      end
    end
  end

  initial begin
    // Neutral chroma, black and white.
    macropixel_queue.push_back(make_item(128, 0, 128, 0, 1'b0));
    macropixel_queue.push_back(make_item(128, 255, 128, 255, 1'b1));
    // All-zero and all-one fields.
    macropixel_queue.push_back(make_item(0, 0, 0, 0, 1'b0));
    macropixel_queue.push_back(make_item(255, 255, 255, 255, 1'b1));
    macropixel_queue.push_back(make_item(0, 255, 255, 0, 1'b0));
    macropixel_queue.push_back(make_item(255, 0, 0, 255, 1'b0));
    // Red clamped high on one pixel, then clamped low.
    macropixel_queue.push_back(make_item(128, 0, 255, 255, 1'b0));
    macropixel_queue.push_back(make_item(128, 255, 0, 0, 1'b0));
    // Blue clamped low, then high.
    macropixel_queue.push_back(make_item(0, 128, 128, 128, 1'b0));
    macropixel_queue.push_back(make_item(255, 128, 128, 128, 1'b0));
    // Green clamped high, then low.
    macropixel_queue.push_back(make_item(0, 200, 0, 255, 1'b0));
    macropixel_queue.push_back(make_item(255, 0, 255, 60, 1'b0));
    // Chroma just around its zero point, where negative products floor.
    macropixel_queue.push_back(make_item(127, 100, 129, 200, 1'b1));
    macropixel_queue.push_back(make_item(129, 1, 127, 254, 1'b0));
    macropixel_queue.push_back(make_item(1, 2, 254, 253, 1'b0));
    macropixel_queue.push_back(make_item(254, 1, 1, 254, 1'b1));
    // Alternating bit patterns.
    macropixel_queue.push_back(make_item(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0));
    macropixel_queue.push_back(make_item(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1));
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      macropixel_queue.push_back(random_macropixel());
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (macropixel_queue.size() > 0 || start) begin
      @(posedge clk);
    end
    while (rgb_expected.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && rgb_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("simulation failed");
    $finish;
  end

endmodule
